>>> hdl/clkm_pkg.sv
package clkm_pkg;

    // field widths
    localparam int HourW = 5;
    localparam int MinW  = 6;
    localparam int SecW  = 6;
    localparam int ModeW = 2;
    localparam int CntW  = 16;

    // wrap points of the time fields
    localparam logic [HourW-1:0] HoursPerDay   = HourW'(24);
    localparam logic [MinW-1:0]  MinsPerHour   = MinW'(60);
    localparam logic [SecW-1:0]  SecsPerMinute = SecW'(60);

    // register reset values
    localparam logic [CntW-1:0] TicksPerSecondRst = CntW'(1000);
    localparam logic [CntW-1:0] HoldTicksRst      = CntW'(1000);
    localparam logic [CntW-1:0] IdleTicksRst      = CntW'(5000);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TICKS_PER_SECOND = 2'd0,
        CFG_HOLD_TICKS       = 2'd1,
        CFG_IDLE_TICKS       = 2'd2,
        CFG_UNUSED           = 2'd3
    } t_cfg_idx;

    // menu modes
    typedef enum logic [ModeW-1:0] {
        MODE_RUN = 2'd0,
        MODE_SEC = 2'd1,
        MODE_MIN = 2'd2,
        MODE_HR  = 2'd3
    } t_mode;

    // time update request from the control unit
    typedef struct packed {
        logic  advance;
        logic  edit;
        logic  up;
        logic  down;
        t_mode field;
    } t_time_req;

    // up/down edit of a time field, up wraps, down sticks at zero
    function automatic logic [MinW-1:0] edit_field(
        input logic [MinW-1:0] v,
        input logic [MinW-1:0] limit,
        input logic            up,
        input logic            down
    );
        logic [MinW-1:0] r;
        r = v;
        if (up && !down) begin
            r = (v + 1'b1 >= limit) ? '0 : v + 1'b1;
        end else if (down && !up) begin
            r = (v == '0) ? '0 : v - 1'b1;
        end
        return r;
    endfunction

    // saturating increment of a 16-bit counter
    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

>>> hdl/clkm_ctrl.sv
module clkm_ctrl
    import clkm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_setup,
    input  logic            i_up,
    input  logic            i_down,
    input  logic [CntW-1:0] i_ticks_per_second,
    input  logic [CntW-1:0] i_hold_ticks,
    input  logic [CntW-1:0] i_idle_ticks,
    output t_mode           o_mode,
    output t_mode           o_mode_next,
    output t_time_req       o_req
);

    t_mode           r_mode, n_mode;
    logic [CntW-1:0] r_div, n_div;
    logic [CntW-1:0] r_hold, n_hold;
    logic [CntW-1:0] r_idle, n_idle;

    // divider, hold and idle counters and menu stepping for one tick
    always_comb begin
        logic [CntW-1:0] div_inc;
        logic [CntW-1:0] hold_inc;
        logic [CntW-1:0] idle_inc;
        logic            stepped;
        t_mode           mode_a;

        div_inc  = sat_inc(r_div);
        hold_inc = sat_inc(r_hold);
        idle_inc = sat_inc(r_idle);
        stepped  = 1'b0;
        mode_a   = r_mode;
        n_div    = r_div;
        n_hold   = '0;
        n_idle   = r_idle;
        o_req    = '0;

        // seconds divider, run mode only
        if (r_mode == MODE_RUN) begin
            if (div_inc >= i_ticks_per_second) begin
                n_div         = '0;
                o_req.advance = 1'b1;
            end else begin
                n_div = div_inc;
            end
        end

        // setup hold steps the menu
        if (i_setup) begin
            if (hold_inc >= i_hold_ticks) begin
                mode_a  = t_mode'(r_mode + 1'b1);
                n_idle  = '0;
                stepped = 1'b1;
            end else begin
                n_hold = hold_inc;
            end
        end

        // idle timeout back to run
        n_mode = mode_a;
        if (mode_a != MODE_RUN && !stepped) begin
            n_idle = idle_inc;
            if (!i_setup && idle_inc >= i_idle_ticks) begin
                n_mode = MODE_RUN;
                n_idle = '0;
            end
        end

        // button edits of the selected field
        if (n_mode != MODE_RUN && (i_up || i_down)) begin
            n_idle     = '0;
            o_req.edit = 1'b1;
        end
        o_req.up    = i_up;
        o_req.down  = i_down;
        o_req.field = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RUN;
            r_div  <= '0;
            r_hold <= '0;
            r_idle <= '0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_div  <= n_div;
            r_hold <= n_hold;
            r_idle <= n_idle;
        end
    end

    assign o_mode      = r_mode;
    assign o_mode_next = n_mode;

endmodule

>>> hdl/clkm_time.sv
module clkm_time
    import clkm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_time_req        i_req,
    output logic [HourW-1:0] o_hours,
    output logic [MinW-1:0]  o_minutes,
    output logic [SecW-1:0]  o_seconds,
    output logic             o_time_diff
);

    logic [HourW-1:0] r_hours, n_hours;
    logic [MinW-1:0]  r_minutes, n_minutes;
    logic [SecW-1:0]  r_seconds, n_seconds;

    // one-second advance with ordered carry, then the edit
    always_comb begin
        logic [HourW-1:0] h_a;
        logic [MinW-1:0]  m_a;
        logic [SecW-1:0]  s_a;

        h_a = r_hours;
        m_a = r_minutes;
        s_a = r_seconds;
        if (i_req.advance) begin
            s_a = r_seconds + 1'b1;
            if (s_a >= SecsPerMinute) begin
                s_a = '0;
                m_a = r_minutes + 1'b1;
                if (m_a >= MinsPerHour) begin
                    m_a = '0;
                    h_a = r_hours + 1'b1;
                    if (h_a >= HoursPerDay) begin
                        h_a = '0;
                    end
                end
            end
        end

        n_hours   = h_a;
        n_minutes = m_a;
        n_seconds = s_a;
        if (i_req.edit) begin
            case (i_req.field)
                MODE_SEC: n_seconds = SecW'(edit_field(MinW'(s_a), MinW'(SecsPerMinute),
                                                       i_req.up, i_req.down));
                MODE_MIN: n_minutes = edit_field(m_a, MinsPerHour, i_req.up, i_req.down);
                MODE_HR:  n_hours   = HourW'(edit_field(MinW'(h_a), MinW'(HoursPerDay),
                                                        i_req.up, i_req.down));
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
        end else if (i_en) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
        end
    end

    assign o_hours     = r_hours;
    assign o_minutes   = r_minutes;
    assign o_seconds   = r_seconds;
    assign o_time_diff = (n_hours != r_hours) || (n_minutes != r_minutes) ||
                         (n_seconds != r_seconds);

endmodule

>>> hdl/clock_with_set_menu.sv
// Clock with a time-set menu, one millisecond tick per input transaction.
// Input channel: i_in_valid / o_in_stall with i_setup_held, i_up_press and
// i_down_press. Output channel: o_out_valid / i_out_stall with o_hours,
// o_minutes, o_seconds, o_mode and o_changed. Every input transaction gives
// exactly one output transaction.
// Path: a tick is taken into an input register and its result appears
// on the output once it moves on. Throughput is one tick per cycle while
// the output is not stalled; the time, divider and menu counters are
// updated as a tick moves from the input register to the output register.
// Stall: while i_out_stall holds a result, the tick in the input register
// waits and o_in_stall rises once that register is full; the state and the
// shown result do not change until the result is taken.
// Configuration: i_cfg_we, i_cfg_idx (0 ticks per second, 1 hold ticks, 2 idle
// ticks, 3 ignored), 16-bit i_cfg_data; users write only while idle, unenforced.
// Reset (synchronous, active low): time 00:00:00, run mode, all counters
// cleared, registers back to 1000 / 1000 / 5000, both channels empty.
module clock_with_set_menu
    import clkm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CntW-1:0]  i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_setup_held,
    input  logic             i_up_press,
    input  logic             i_down_press,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [HourW-1:0] o_hours,
    output logic [MinW-1:0]  o_minutes,
    output logic [SecW-1:0]  o_seconds,
    output logic [ModeW-1:0] o_mode,
    output logic             o_changed
);

    logic [CntW-1:0] r_tps, r_hold_ticks, r_idle_ticks;
    logic            r_in_vld, r_setup, r_up, r_down;
    logic            r_out_vld, r_changed;
    logic            move;
    t_mode           mode, mode_next;
    t_time_req       req;
    logic            time_diff;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= TicksPerSecondRst;
            r_hold_ticks <= HoldTicksRst;
            r_idle_ticks <= IdleTicksRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TICKS_PER_SECOND: r_tps        <= i_cfg_data;
                CFG_HOLD_TICKS:       r_hold_ticks <= i_cfg_data;
                CFG_IDLE_TICKS:       r_idle_ticks <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    // tick moves to the output when the result slot is free or being taken
    assign move       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !move;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_setup <= i_setup_held;
            r_up    <= i_up_press;
            r_down  <= i_down_press;
        end
    end

    clkm_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (move),
        .i_setup            (r_setup),
        .i_up               (r_up),
        .i_down             (r_down),
        .i_ticks_per_second (r_tps),
        .i_hold_ticks       (r_hold_ticks),
        .i_idle_ticks       (r_idle_ticks),
        .o_mode             (mode),
        .o_mode_next        (mode_next),
        .o_req              (req)
    );

    clkm_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (move),
        .i_req       (req),
        .o_hours     (o_hours),
        .o_minutes   (o_minutes),
        .o_seconds   (o_seconds),
        .o_time_diff (time_diff)
    );

    // output valid; the time and mode registers hold the shown result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_changed <= time_diff || (mode_next != mode);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_mode      = mode;
    assign o_changed   = r_changed;

endmodule

>>> sim/clock_with_set_menu_tb.sv
`timescale 1ns / 1ps

module clock_with_set_menu_tb;
    import clkm_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PHASE_ITEMS   = 20;
    localparam int unsigned NUM_PHASES    = 6;
    localparam int unsigned LONG_HOLD_AT  = 200;
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned DIR_ROWS      = 26;

    // one display reading as the block shows it
    typedef struct packed {
        logic [HourW-1:0] hours;
        logic [MinW-1:0]  minutes;
        logic [SecW-1:0]  seconds;
        t_mode            mode;
        logic             changed;
    } t_reading;

    // one directed step: a register write or a tick transaction
    typedef struct packed {
        logic            is_cfg;
        t_cfg_idx        reg_idx;
        logic [CntW-1:0] value;
        logic            setup;
        logic            up;
        logic            down;
        logic            typed;
        t_reading        want;
    } t_step_row;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_we     = 1'b0;
    logic [1:0]       i_cfg_idx    = '0;
    logic [CntW-1:0]  i_cfg_data   = '0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic             i_setup_held = 1'b0;
    logic             i_up_press   = 1'b0;
    logic             i_down_press = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic [HourW-1:0] o_hours;
    logic [MinW-1:0]  o_minutes;
    logic [SecW-1:0]  o_seconds;
    logic [ModeW-1:0] o_mode;
    logic             o_changed;

    // clock model state and its register copies
    logic [HourW-1:0] clk_hours   = '0;
    logic [MinW-1:0]  clk_minutes = '0;
    logic [SecW-1:0]  clk_seconds = '0;
    t_mode            clk_mode    = MODE_RUN;
    logic [CntW-1:0]  tick_div    = '0;
    logic [CntW-1:0]  hold_run    = '0;
    logic [CntW-1:0]  idle_run    = '0;
    logic [CntW-1:0]  cfg_tps     = TicksPerSecondRst;
    logic [CntW-1:0]  cfg_hold    = HoldTicksRst;
    logic [CntW-1:0]  cfg_idle    = IdleTicksRst;

    t_reading    reading_q [$];
    t_reading    oldest;
    int unsigned ticks_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    bit          long_done   = 1'b0;

    // directed steps: run ticks, presses in run, zero and extreme registers,
    // every set mode in turn, down at zero, up and down together, idle timeout
    t_step_row dir_rows [DIR_ROWS] = '{
        '{0, CFG_UNUSED, 0, 0, 0, 0, 1, '{0, 0, 0, MODE_RUN, 0}},
        '{0, CFG_UNUSED, 0, 0, 1, 1, 1, '{0, 0, 0, MODE_RUN, 0}},
        '{1, CFG_TICKS_PER_SECOND, 16'h0000, 0, 0, 0, 0, '0},
        '{1, CFG_HOLD_TICKS, 16'h0001, 0, 0, 0, 0, '0},
        '{1, CFG_IDLE_TICKS, 16'h0003, 0, 0, 0, 0, '0},
        '{1, CFG_UNUSED, 16'hFFFF, 0, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 0, 1, '{0, 0, 1, MODE_RUN, 1}},
        '{0, CFG_UNUSED, 0, 1, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 1, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 1, 1, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 1, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 1, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 1, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 1, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 1, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 1, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 1, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 0, 0, '0},
        '{1, CFG_TICKS_PER_SECOND, 16'hFFFF, 0, 0, 0, 0, '0},
        '{1, CFG_HOLD_TICKS, 16'h0000, 0, 0, 0, 0, '0},
        '{1, CFG_IDLE_TICKS, 16'h0000, 0, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 1, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 1, 1, 0, 0, '0},
        '{0, CFG_UNUSED, 0, 0, 0, 0, 0, '0}
    };

    clock_with_set_menu u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_setup_held (i_setup_held),
        .i_up_press   (i_up_press),
        .i_down_press (i_down_press),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hours      (o_hours),
        .o_minutes    (o_minutes),
        .o_seconds    (o_seconds),
        .o_mode       (o_mode),
        .o_changed    (o_changed)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // up wraps past the top value, down sticks at zero, both cancel
    function automatic logic [MinW-1:0] bump_field(
        input logic [MinW-1:0] v,
        input logic [MinW-1:0] top,
        input logic            up,
        input logic            down
    );
        if (up && !down) return (v == top) ? '0 : v + 1'b1;
        if (down && !up) return (v == '0) ? '0 : v - 1'b1;
        return v;
    endfunction

    // one second forward with ordered carries
    function automatic void advance_second();
        if (clk_seconds == SecsPerMinute - 1'b1) begin
            clk_seconds = '0;
            if (clk_minutes == MinsPerHour - 1'b1) begin
                clk_minutes = '0;
                clk_hours = (clk_hours == HoursPerDay - 1'b1) ? '0 : clk_hours + 1'b1;
            end else begin
                clk_minutes = clk_minutes + 1'b1;
            end
        end else begin
            clk_seconds = clk_seconds + 1'b1;
        end
    endfunction

    // applies one tick to the clock model and returns the reading it shows
    function automatic t_reading next_reading(
        input logic setup,
        input logic up,
        input logic down
    );
        logic [HourW+MinW+SecW+ModeW-1:0] prior;
        logic                             stepped;
        prior = {clk_hours, clk_minutes, clk_seconds, clk_mode};
        stepped = 1'b0;
        // divider runs in run mode only
        if (clk_mode == MODE_RUN) begin
            tick_div = (tick_div == '1) ? tick_div : tick_div + 1'b1;
            if (tick_div >= cfg_tps) begin
                tick_div = '0;
                advance_second();
            end
        end
        // setup hold steps the menu
        if (setup) begin
            hold_run = (hold_run == '1) ? hold_run : hold_run + 1'b1;
            if (hold_run >= cfg_hold) begin
                clk_mode = t_mode'(clk_mode + 2'd1);
                hold_run = '0;
                idle_run = '0;
                stepped = 1'b1;
            end
        end else begin
            hold_run = '0;
        end
        // idle timeout back to run
        if (clk_mode != MODE_RUN && !stepped) begin
            idle_run = (idle_run == '1) ? idle_run : idle_run + 1'b1;
            if (!setup && idle_run >= cfg_idle) begin
                clk_mode = MODE_RUN;
                idle_run = '0;
            end
        end
        // field edit in a set mode
        if (clk_mode != MODE_RUN && (up || down)) begin
            idle_run = '0;
            case (clk_mode)
                MODE_SEC: clk_seconds = bump_field(clk_seconds, SecsPerMinute - 1'b1, up, down);
                MODE_MIN: clk_minutes = bump_field(clk_minutes, MinsPerHour - 1'b1, up, down);
                default:  clk_hours = HourW'(bump_field(MinW'(clk_hours),
                                             MinW'(HoursPerDay - 1'b1), up, down));
            endcase
        end
        return '{clk_hours, clk_minutes, clk_seconds, clk_mode,
                 prior != {clk_hours, clk_minutes, clk_seconds, clk_mode}};
    endfunction

    function automatic bit field_at_top();
        case (clk_mode)
            MODE_SEC: return clk_seconds == SecsPerMinute - 1'b1;
            MODE_MIN: return clk_minutes == MinsPerHour - 1'b1;
            MODE_HR:  return clk_hours == HoursPerDay - 1'b1;
            default:  return 1'b1;
        endcase
    endfunction

    // offer one tick transaction, sender idles in bursts
    task automatic send_tick(
        input logic     setup,
        input logic     up,
        input logic     down,
        input logic     typed,
        input t_reading want
    );
        int unsigned gap;
        t_reading    guess;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_setup_held <= setup;
        i_up_press   <= up;
        i_down_press <= down;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        guess = next_reading(setup, up, down);
        reading_q.push_back(typed ? want : guess);
        ticks_sent++;
    endtask

    task automatic tick(input logic setup, input logic up, input logic down);
        send_tick(setup, up, down, 1'b0, '0);
    endtask

    // let every pending reading come out before touching registers
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (reading_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CntW-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TICKS_PER_SECOND: cfg_tps = value;
            CFG_HOLD_TICKS:       cfg_hold = value;
            CFG_IDLE_TICKS:       cfg_idle = value;
            default: ;
        endcase
    endtask

    task automatic load_config(
        input logic [CntW-1:0] tps,
        input logic [CntW-1:0] hold,
        input logic [CntW-1:0] idle
    );
        write_reg(CFG_TICKS_PER_SECOND, tps);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_IDLE_TICKS, idle);
    endtask

    // walk the menu setting every field to its top value, optionally
    // pressing up once more to wrap it, then back to run
    task automatic roll_time(input bit overflow);
        t_mode       order [4] = '{MODE_SEC, MODE_MIN, MODE_HR, MODE_RUN};
        int unsigned guard;
        foreach (order[i]) begin
            guard = 0;
            while (clk_mode != order[i] && guard < 24) begin
                tick(1'b1, 1'b0, 1'b0);
                guard++;
            end
            guard = 0;
            while (clk_mode == order[i] && order[i] != MODE_RUN && !field_at_top()
                   && guard < 70) begin
                tick(1'b0, 1'b1, 1'b0);
                guard++;
            end
            if (overflow && clk_mode == order[i] && order[i] != MODE_RUN)
                tick(1'b0, 1'b1, 1'b0);
        end
        repeat (2) tick(1'b0, 1'b0, 1'b0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reading_q.size() == 0) begin
                $error("unexpected transaction: %0d:%0d:%0d mode %0d",
                       o_hours, o_minutes, o_seconds, o_mode);
                errors++;
            end else begin
                oldest = reading_q.pop_front();
                if (o_hours !== oldest.hours) begin
                    $error("hours: expected %0d, got %0d", oldest.hours, o_hours);
                    errors++;
                end
                if (o_minutes !== oldest.minutes) begin
                    $error("minutes: expected %0d, got %0d", oldest.minutes, o_minutes);
                    errors++;
                end
                if (o_seconds !== oldest.seconds) begin
                    $error("seconds: expected %0d, got %0d", oldest.seconds, o_seconds);
                    errors++;
                end
                if (o_mode !== oldest.mode) begin
                    $error("mode: expected %0d, got %0d", oldest.mode, o_mode);
                    errors++;
                end
                if (o_changed !== oldest.changed) begin
                    $error("changed: expected %0d, got %0d", oldest.changed, o_changed);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall patterns, with one long hold-off to back up the input
    initial begin
        int unsigned pick;
        int unsigned span;
        int unsigned k;
        int unsigned n;
        forever begin
            if (!long_done && ticks_sent >= LONG_HOLD_AT) begin
                long_done = 1'b1;
                for (n = 0; n < LONG_HOLD; n++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            pick = $urandom_range(0, 2);
            span = $urandom_range(8, 40);
            k    = $urandom_range(2, 5);
            for (n = 0; n < span; n++) begin
                @(negedge i_clk);
                case (pick)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 1);
                    default: i_out_stall <= (n % k == 0);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int unsigned p;
        int unsigned goal;
        int unsigned pick;
        int unsigned n;
        int unsigned r;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed steps
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
                send_tick(dir_rows[i].setup, dir_rows[i].up, dir_rows[i].down,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, each under its own register setting
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_config(16'd1, 16'd1, 16'hFFFF);
                1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_config(16'd1, 16'd1, 16'd1);
                default: load_config(16'(($urandom_range(0, 2) == 0) ? $urandom_range(7, 40)
                                                                     : $urandom_range(1, 6)),
                                     16'($urandom_range(1, 5)), 16'($urandom_range(2, 40)));
            endcase
            // full roll to midnight and field wraps
            if (p == 0) begin
                roll_time(1'b0);
                roll_time(1'b1);
            end
            goal = ticks_sent + PHASE_ITEMS;
            while (ticks_sent < goal) begin
                pick = $urandom_range(0, 19);
                if (pick < 10) begin
                    // menu visit: hold setup, then a burst of edits
                    n = (cfg_hold <= 6) ? 32'(cfg_hold) : $urandom_range(1, 6);
                    if (n > 1 && $urandom_range(0, 4) == 0) n--;
                    repeat (n) tick(1'b1, 1'b0, 1'b0);
                    repeat ($urandom_range(0, 20)) begin
                        r = $urandom_range(0, 9);
                        case (r)
                            0, 1, 2, 3, 4: tick(1'b0, 1'b1, 1'b0);
                            5, 6:          tick(1'b0, 1'b0, 1'b1);
                            7:             tick(1'b0, 1'b1, 1'b1);
                            8:             tick(1'b0, 1'b0, 1'b0);
                            default: tick(1'b1, 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)));
                        endcase
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        n = (cfg_idle <= 40) ? 32'(cfg_idle) + 1 : $urandom_range(1, 5);
                        repeat (n) tick(1'b0, 1'b0, 1'b0);
                    end
                end else if (pick < 15) begin
                    repeat ($urandom_range(1, 15)) tick(1'b0, 1'b0, 1'b0);
                end else if (pick < 19 || cfg_hold > 4 || cfg_idle < 2) begin
                    repeat ($urandom_range(1, 10))
                        tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                end else begin
                    roll_time(1'b1);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && reading_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
